// ===== sv/framed_serial_rx_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the framed serial receive deframer
// Concurrent assertion wrappers that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FRAMED_SERIAL_RX_DEFRAMER_MACROS_SVH
`define FRAMED_SERIAL_RX_DEFRAMER_MACROS_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define FSRD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fsrd assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define FSRD_ASSERT_IMPL(lbl, clk, rstn, cond, cons) \
  `FSRD_ASSERT(lbl, clk, rstn, (cond) |-> (cons))

`else

`define FSRD_ASSERT(lbl, clk, rstn, prop)
`define FSRD_ASSERT_IMPL(lbl, clk, rstn, cond, cons)

`endif

`endif

// ===== sv/fsrd_pkg.sv =====
// ---------------------------------------------------------------------------
// Deframer package
// Types, codes, constants and the CRC byte update shared by the deframer.
// ---------------------------------------------------------------------------
package fsrd_pkg;

  localparam int unsigned NUM_CHANNELS = 2;
  localparam int unsigned CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [7:0]  MAGIC_FIRST  = 8'h7E;
  localparam logic [7:0]  MAGIC_SECOND = 8'hA5;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_RESIDUE  = 16'hF0B8;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd2;
  localparam logic [15:0] MAX_LEN_RESET = 16'd106;

  typedef enum logic [2:0] {
    MODE_MAGIC1 = 3'd0,
    MODE_MAGIC2 = 3'd1,
    MODE_LEN_HI = 3'd2,
    MODE_LEN_LO = 3'd3,
    MODE_DATA   = 3'd4
  } fsrd_mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_GOOD    = 3'd1,
    EV_CRC_ERR = 3'd2,
    EV_LEN_REJ = 3'd3,
    EV_NO_BUF  = 3'd4
  } fsrd_event_e;

  // Receive state of one channel, as kept in the state memory.
  typedef struct packed {
    fsrd_mode_e  mode;
    logic [15:0] length;
    logic [15:0] bytes_rcvd;
    logic [15:0] crc;
    logic [31:0] good_cnt;
    logic [31:0] sync_cnt;
    logic        buf_held;
  } fsrd_state_t;

  localparam int unsigned STATE_W = $bits(fsrd_state_t);

  localparam fsrd_state_t STATE_RESET = '{
    mode:       MODE_MAGIC1,
    length:     16'd0,
    bytes_rcvd: 16'd0,
    crc:        CRC_INIT,
    good_cnt:   32'd0,
    sync_cnt:   32'd0,
    buf_held:   1'b0
  };

  // Result of one received byte.
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [15:0] data_index;
    fsrd_event_e frame_event;
    logic [15:0] payload_length;
    logic [31:0] good_frames;
    logic [31:0] syncs;
  } fsrd_result_t;

  // Reflected CRC-16 update over one byte, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/fsrd_if.sv =====
// ---------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for received bytes, results and the length register.
// ---------------------------------------------------------------------------
interface fsrd_in_if;
  logic       valid;
  logic       ready;
  logic       channel;
  logic [7:0] rx_byte;
  logic       buffer_ready;

  modport source (output valid, channel, rx_byte, buffer_ready, input ready);
  modport sink   (input valid, channel, rx_byte, buffer_ready, output ready);
endinterface

interface fsrd_out_if;
  logic        valid;
  logic        ready;
  logic        out_channel;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [15:0] data_index;
  logic [2:0]  frame_event;
  logic [15:0] payload_length;
  logic [31:0] good_frames;
  logic [31:0] syncs;

  modport source (output valid, out_channel, data_valid, data_byte, data_index, frame_event,
                  payload_length, good_frames, syncs, input ready);
  modport sink   (input valid, out_channel, data_valid, data_byte, data_index, frame_event,
                  payload_length, good_frames, syncs, output ready);
endinterface

interface fsrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/framed_serial_rx_deframer.sv =====
// ---------------------------------------------------------------------------
// Framed serial receive deframer
// Per-channel frame hunt, length check, body streaming and CRC-16/X.25 check.
// ---------------------------------------------------------------------------
// Usage:
// Each request on rx_i carries one received byte, the channel it came in on
// and whether a receive buffer can be taken. Every request produces exactly
// one request on res_o, in order: the body byte with its index when the
// channel is inside a frame, a frame event (good end, CRC error, rejected
// length, dropped for lack of a buffer) and that channel's frame counters.
// The largest accepted length field is written through cfg_i while the block
// is idle; cfg_i is always ready.
// The result passes the update stage and the output register on to res_o.
// Throughput is one byte per cycle while res_o is not stalled, also when
// consecutive bytes belong to the same channel: the channel state lives in a
// small memory with registered read data, and a forwarding register covers
// the write of the byte before.
// When the receiver stalls res_o, one result waits in the output register and
// one byte waits in the update stage; rx_i drops ready only when both hold.
// Reset returns every channel to hunting the first magic byte with cleared
// counters at once, through per-channel valid bits; no clearing pass is run.
// The length register resets to 106.
// ---------------------------------------------------------------------------
`include "framed_serial_rx_deframer_macros.svh"

module framed_serial_rx_deframer import fsrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsrd_in_if.sink    rx_i,
  fsrd_out_if.source res_o,
  fsrd_cfg_if.sink   cfg_i
);

  // Length limit register.
  logic [15:0] max_len_q;

  // Update stage: the accepted byte while its channel state is being read.
  logic             s1_valid_q;
  logic             s1_channel_q;
  logic [7:0]       s1_byte_q;
  logic             s1_buf_ready_q;
  logic             s1_adv;
  logic             s1_ch_ok;
  logic [CH_AW-1:0] s1_addr;

  // State memory, its valid bits and the forwarding path.
  logic [NUM_CHANNELS-1:0] st_valid_q;
  logic [STATE_W-1:0]      ram_rdata;
  logic                    ram_wr_en;
  logic                    rx_accept;
  logic [CH_AW-1:0]        rx_addr;
  logic                    fwd_hit_q;
  fsrd_state_t             fwd_state_q;
  fsrd_state_t             cur_state;
  fsrd_state_t             nxt_state;
  fsrd_result_t            upd_result;

  // Output register.
  logic         out_valid_q;
  logic         out_channel_q;
  fsrd_result_t out_result_q;

  assign cfg_i.ready = 1'b1;

  // The update stage moves on whenever the output register is free or drains.
  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready  = !s1_valid_q || s1_adv;
  assign rx_accept   = rx_i.valid && rx_i.ready;
  assign rx_addr     = CH_AW'(rx_i.channel);
  assign s1_addr     = CH_AW'(s1_channel_q);
  assign s1_ch_ok    = (32'(s1_channel_q) < NUM_CHANNELS);
  assign ram_wr_en   = s1_adv && s1_ch_ok;

  fsrd_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (s1_addr),
    .wr_data_i (nxt_state),
    .rd_en_i   (rx_accept),
    .rd_addr_i (rx_addr),
    .rd_data_o (ram_rdata)
  );

  // The memory returns the old word when the byte ahead writes the same
  // channel in the cycle of the read, so that write is taken from the
  // forwarding register instead. A channel never written reads as reset.
  always_comb begin
    if (fwd_hit_q) begin
      cur_state = fwd_state_q;
    end else if (st_valid_q[s1_addr]) begin
      cur_state = fsrd_state_t'(ram_rdata);
    end else begin
      cur_state = STATE_RESET;
    end
  end

  fsrd_update u_update (
    .state_i        (cur_state),
    .rx_byte_i      (s1_byte_q),
    .buffer_ready_i (s1_buf_ready_q),
    .max_len_i      (max_len_q),
    .state_o        (nxt_state),
    .result_o       (upd_result)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAX_LEN_RESET;
      s1_valid_q  <= 1'b0;
      st_valid_q  <= '0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        max_len_q <= cfg_i.data;
      end
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      if (ram_wr_en) begin
        st_valid_q[s1_addr] <= 1'b1;
      end
      if (rx_i.ready) begin
        fwd_hit_q <= rx_accept && ram_wr_en && (s1_addr == rx_addr);
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      s1_channel_q   <= rx_i.channel;
      s1_byte_q      <= rx_i.rx_byte;
      s1_buf_ready_q <= rx_i.buffer_ready;
    end
    if (ram_wr_en) begin
      fwd_state_q <= nxt_state;
    end
    if (s1_adv) begin
      out_channel_q <= s1_channel_q;
      out_result_q  <= s1_ch_ok ? upd_result : '0;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.out_channel    = out_channel_q;
  assign res_o.data_valid     = out_result_q.data_valid;
  assign res_o.data_byte      = out_result_q.data_byte;
  assign res_o.data_index     = out_result_q.data_index;
  assign res_o.frame_event    = out_result_q.frame_event;
  assign res_o.payload_length = out_result_q.payload_length;
  assign res_o.good_frames    = out_result_q.good_frames;
  assign res_o.syncs          = out_result_q.syncs;

  // A body byte carries no header event.
  `FSRD_ASSERT_IMPL(a_body_event, clk_i, rst_ni, out_valid_q && out_result_q.data_valid,
    out_result_q.frame_event == EV_NONE || out_result_q.frame_event == EV_GOOD ||
    out_result_q.frame_event == EV_CRC_ERR)

  // Frame end events come only with the last body byte.
  `FSRD_ASSERT_IMPL(a_end_on_body, clk_i, rst_ni,
    out_valid_q && (out_result_q.frame_event == EV_GOOD ||
    out_result_q.frame_event == EV_CRC_ERR), out_result_q.data_valid)

  // An empty output register never holds back input.
  `FSRD_ASSERT_IMPL(a_no_bubble, clk_i, rst_ni, !out_valid_q, rx_i.ready)

  // Forwarding is only in effect for a byte in the update stage.
  `FSRD_ASSERT_IMPL(a_fwd_live, clk_i, rst_ni, fwd_hit_q, s1_valid_q)

endmodule

// ===== sv/fsrd_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fsrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/fsrd_update.sv =====
// ---------------------------------------------------------------------------
// Deframer state update
// Next channel state and result for one received byte.
// ---------------------------------------------------------------------------
module fsrd_update import fsrd_pkg::*; (
  input  fsrd_state_t  state_i,
  input  logic [7:0]   rx_byte_i,
  input  logic         buffer_ready_i,
  input  logic [15:0]  max_len_i,
  output fsrd_state_t  state_o,
  output fsrd_result_t result_o
);

  always_comb begin
    fsrd_state_t  nxt;
    fsrd_result_t res;
    logic [15:0]  crc_new;
    logic [15:0]  len_new;
    logic [15:0]  cnt_new;
    logic         held_new;

    nxt      = state_i;
    res      = '0;
    crc_new  = crc_byte(state_i.crc, rx_byte_i);
    len_new  = state_i.length | {8'h00, rx_byte_i};
    cnt_new  = state_i.bytes_rcvd + 16'd1;
    held_new = state_i.buf_held | buffer_ready_i;
    res.frame_event = EV_NONE;

    case (state_i.mode)
      MODE_DATA: begin
        res.data_valid = 1'b1;
        res.data_byte  = rx_byte_i;
        res.data_index = state_i.bytes_rcvd;
        nxt.bytes_rcvd = cnt_new;
        nxt.crc        = crc_new;
        if (cnt_new == state_i.length) begin
          nxt.mode = MODE_MAGIC1;
          if (crc_new == CRC_RESIDUE) begin
            res.frame_event    = EV_GOOD;
            res.payload_length = state_i.length - MIN_FRAME_LEN;
            nxt.buf_held       = 1'b0;
            nxt.good_cnt       = state_i.good_cnt + 32'd1;
          end else begin
            res.frame_event = EV_CRC_ERR;
          end
        end
      end
      MODE_MAGIC2: begin
        nxt.mode = (rx_byte_i == MAGIC_SECOND) ? MODE_LEN_HI : MODE_MAGIC1;
      end
      MODE_LEN_HI: begin
        nxt.length = {rx_byte_i, 8'h00};
        nxt.mode   = MODE_LEN_LO;
      end
      MODE_LEN_LO: begin
        nxt.length = len_new;
        if (len_new <= max_len_i && len_new >= MIN_FRAME_LEN) begin
          nxt.bytes_rcvd = 16'd0;
          nxt.crc        = CRC_INIT;
          nxt.sync_cnt   = state_i.sync_cnt + 32'd1;
          nxt.buf_held   = held_new;
          if (held_new) begin
            nxt.mode = MODE_DATA;
          end else begin
            nxt.mode        = MODE_MAGIC1;
            res.frame_event = EV_NO_BUF;
          end
        end else begin
          nxt.mode        = MODE_MAGIC1;
          res.frame_event = EV_LEN_REJ;
        end
      end
      default: begin
        // Hunting the first magic byte; codes without meaning hunt as well.
        nxt.mode = (rx_byte_i == MAGIC_FIRST) ? MODE_MAGIC2 : MODE_MAGIC1;
      end
    endcase

    res.good_frames = nxt.good_cnt;
    res.syncs       = nxt.sync_cnt;
    state_o  = nxt;
    result_o = res;
  end

endmodule
